// ----- design/ctts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctts_pkg
// Types and constants shared by the camera trigger time sync block.
// ----------------------------------------------------------------------------
package ctts_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int ID_W      = 29;
	localparam int TS_W      = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLOB_ID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd3;

	localparam logic [ID_W-1:0] RST_SYNC_ID = 29'd83820783;
	localparam logic [ID_W-1:0] RST_GLOB_ID = 29'd83821039;
	localparam logic [TS_W-1:0] RST_CALIB   = 32'd10000;
	localparam logic [TS_W-1:0] RST_TIMEOUT = 32'd2000000;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAG,
		ST_CYC,
		ST_BASE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// window control from the sequencer to the window storage
	typedef struct packed {
		logic wr_sync;
		logic wr_glob;
		logic shift_sync;
		logic shift_glob;
		logic rot_sync;
		logic rot_glob;
	} win_ctl_t;

	// "a past b": a - b lies in the lower half of the wrapping range
	function automatic logic is_past(input logic [TS_W-1:0] a, input logic [TS_W-1:0] b);
		logic [TS_W-1:0] d;
		d = a - b;
		return ~d[TS_W-1];
	endfunction

endpackage

`default_nettype wire

// ----- design/ctts_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctts interfaces
// Frame input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ctts_frame_if import ctts_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            command;
	logic [ID_W-1:0] frame_id;
	logic [TS_W-1:0] payload;
	logic [TS_W-1:0] now;

	modport source (output valid, command, frame_id, payload, now, input ready);
	modport sink (input valid, command, frame_id, payload, now, output ready);
endinterface

interface ctts_result_if import ctts_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            fire;
	logic            running;
	logic [TS_W-1:0] trigger_count;
	logic [TS_W-1:0] min_lag;
	logic [TS_W-1:0] cycle_time;
	logic [TS_W-1:0] pending_trigger;
	logic            search_overflow;

	modport source (output valid, fire, running, trigger_count, min_lag, cycle_time,
		pending_trigger, search_overflow, input ready);
	modport sink (input valid, fire, running, trigger_count, min_lag, cycle_time,
		pending_trigger, search_overflow, output ready);
endinterface

interface ctts_cfg_if import ctts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [TS_W-1:0]      data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ----- design/camera_trigger_time_sync_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: an item that does not plan goes from accept through ST_FINISH to the result;
//   a planning item first passes ST_LAG, ST_CYC, ST_BASE and ST_SEARCH (0..SEARCH_LIMIT candidate steps).
// Throughput: one item at a time; the shared 32-bit add/subtract unit walks the
//   windows (one entry per cycle) and then the candidate search (one step per cycle).
// Reset: arst_n clears phase, fills, timing registers, counter and configuration
//   defaults at once; the windows are not cleared and are read only once filled.
// ----------------------------------------------------------------------------
// camera_trigger_time_sync_core
// Camera trigger time synchronizer: collects sync and global stamps, derives
// lag and cycle, plans and fires triggers, drops back on bus silence.
// ----------------------------------------------------------------------------
module camera_trigger_time_sync_core import ctts_pkg::*; #(
	parameter int WINDOW       = 10,
	parameter int SEARCH_LIMIT = 256
) (
	input wire logic     clk,
	input wire logic     arst_n,
	ctts_frame_if.sink   frames,
	ctts_result_if.source results,
	ctts_cfg_if.sink     cfg
);

	localparam int IW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);
	localparam int SW = $clog2(SEARCH_LIMIT + 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW);
	localparam logic [IW-1:0] K_LAST    = IW'(WINDOW - 1);
	localparam logic [SW-1:0] STEP_MAX  = SW'(SEARCH_LIMIT);

	// configuration
	logic [ID_W-1:0] sync_id_q, glob_id_q;
	logic [TS_W-1:0] calib_q, timeout_q;

	// control state
	state_t          state_q, state_d;
	logic [FW-1:0]   sync_fill_q, glob_fill_q;
	logic            running_q;
	logic [TS_W-1:0] pend_q, lag_q, cycle_q, last_act_q, fire_cnt_q;
	logic            ovf_q;
	logic [IW-1:0]   k_q;
	logic [SW-1:0]   step_q;
	logic [TS_W-1:0] now_q;
	logic            fire_q;

	// output register
	logic            out_valid_q;
	logic            o_fire_q, o_running_q, o_ovf_q;
	logic [TS_W-1:0] o_count_q, o_lag_q, o_cycle_q, o_pend_q;

	// ------------------------------------------------------------------
	// accept-cycle decode
	// ------------------------------------------------------------------
	logic            accept;
	logic            is_frame, sync_match, glob_match;
	logic            s_wr, g_wr;
	logic [FW-1:0]   sync_fill_d, glob_fill_d;
	logic            enter_run;
	logic            run_sync_hit, run_glob_hit;
	logic [TS_W-1:0] last_act_d, idle_span;
	logic            fire_now, silence;
	logic            start_plan;

	assign accept     = frames.valid && frames.ready;
	assign is_frame   = frames.command == CMD_FRAME;
	assign sync_match = is_frame && frames.frame_id == sync_id_q;
	assign glob_match = is_frame && frames.frame_id == glob_id_q;

	assign s_wr = !running_q && sync_match && sync_fill_q < FILL_FULL;
	assign g_wr = !running_q && glob_match && glob_fill_q < FILL_FULL
		&& frames.payload != '0;
	assign sync_fill_d = s_wr ? sync_fill_q + 1'b1 : sync_fill_q;
	assign glob_fill_d = g_wr ? glob_fill_q + 1'b1 : glob_fill_q;
	assign enter_run   = !running_q && is_frame && sync_fill_d >= FILL_FULL
		&& glob_fill_d >= FILL_FULL;

	// while running, an identifier matching both counts as sync only
	assign run_sync_hit = running_q && sync_match;
	assign run_glob_hit = running_q && !sync_match && glob_match;
	assign last_act_d   = (run_sync_hit || run_glob_hit) ? frames.now : last_act_q;
	assign idle_span    = frames.now - last_act_d;
	assign fire_now     = running_q && is_past(frames.now, pend_q);
	assign silence      = running_q && idle_span > timeout_q;
	assign start_plan   = enter_run || fire_now;

	// ------------------------------------------------------------------
	// window storage
	// ------------------------------------------------------------------
	win_ctl_t        win_ctl;
	logic [TS_W-1:0] sync1, arr0, glob0, glob1, glob_last;

	ctts_windows #(
		.WINDOW (WINDOW)
	) u_windows (
		.clk       (clk),
		.ctl       (win_ctl),
		.sync_idx  (sync_fill_q[IW-1:0]),
		.glob_idx  (glob_fill_q[IW-1:0]),
		.now       (frames.now),
		.payload   (frames.payload),
		.sync1     (sync1),
		.arr0      (arr0),
		.glob0     (glob0),
		.glob1     (glob1),
		.glob_last (glob_last)
	);

	// ------------------------------------------------------------------
	// shared add/subtract unit
	// ------------------------------------------------------------------
	logic [TS_W-1:0] op_a, op_b, alu_sum;
	logic            op_sub;
	logic            cand_past;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_LAG: begin
				op_a   = sync1;
				op_b   = arr0;
				op_sub = 1'b1;
			end
			ST_CYC: begin
				op_a   = glob1;
				op_b   = glob0;
				op_sub = 1'b1;
			end
			ST_BASE: begin
				if (k_q == '0) begin
					op_a   = glob_last;
					op_b   = lag_q;
					op_sub = 1'b1;
				end else begin
					op_a = pend_q;
					op_b = calib_q;
				end
			end
			ST_SEARCH: begin
				op_a = pend_q;
				op_b = cycle_q;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign alu_sum   = op_a + (op_b ^ {TS_W{op_sub}}) + {{(TS_W-1){1'b0}}, op_sub};
	assign cand_past = is_past(now_q, pend_q);

	logic scan_take, out_load, search_stop;

	assign scan_take   = k_q != K_LAST
		&& (k_q == '0 || alu_sum < (state_q == ST_LAG ? lag_q : cycle_q));
	assign search_stop = cycle_q == '0 || step_q >= STEP_MAX;
	assign out_load    = !out_valid_q || results.ready;

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = start_plan ? ST_LAG : ST_FINISH;
				end
			end
			ST_LAG: begin
				if (k_q == K_LAST) begin
					state_d = ST_CYC;
				end
			end
			ST_CYC: begin
				if (k_q == K_LAST) begin
					state_d = ST_BASE;
				end
			end
			ST_BASE: begin
				if (k_q != '0) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!cand_past || search_stop) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		frames.ready = 1'b0;
		win_ctl      = '0;
		case (state_q)
			ST_IDLE: begin
				frames.ready       = 1'b1;
				win_ctl.wr_sync    = accept && s_wr;
				win_ctl.wr_glob    = accept && g_wr;
				win_ctl.shift_sync = accept && run_sync_hit;
				win_ctl.shift_glob = accept && run_glob_hit;
			end
			ST_LAG: begin
				win_ctl.rot_sync = 1'b1;
			end
			ST_CYC: begin
				win_ctl.rot_glob = 1'b1;
			end
			default: begin
				frames.ready = 1'b0;
			end
		endcase
	end

	assign cfg.ready = 1'b1;

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_id_q   <= RST_SYNC_ID;
			glob_id_q   <= RST_GLOB_ID;
			calib_q     <= RST_CALIB;
			timeout_q   <= RST_TIMEOUT;
			state_q     <= ST_IDLE;
			sync_fill_q <= '0;
			glob_fill_q <= '0;
			running_q   <= 1'b0;
			pend_q      <= '0;
			lag_q       <= '0;
			cycle_q     <= '0;
			last_act_q  <= '0;
			fire_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					REG_SYNC_ID: sync_id_q <= cfg.data[ID_W-1:0];
					REG_GLOB_ID: glob_id_q <= cfg.data[ID_W-1:0];
					REG_CALIB:   calib_q   <= cfg.data;
					REG_TIMEOUT: timeout_q <= cfg.data;
					default:     calib_q   <= calib_q;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept) begin
						if (!running_q) begin
							sync_fill_q <= sync_fill_d;
							glob_fill_q <= glob_fill_d;
							if (enter_run) begin
								running_q  <= 1'b1;
								last_act_q <= frames.now;
							end
						end else begin
							last_act_q <= last_act_d;
							if (fire_now) begin
								fire_cnt_q <= fire_cnt_q + 1'b1;
							end
							// drop back to collecting on silence
							if (silence) begin
								running_q   <= 1'b0;
								sync_fill_q <= '0;
								glob_fill_q <= '0;
							end
						end
					end
				end
				ST_LAG: begin
					if (scan_take) begin
						lag_q <= alu_sum;
					end
					k_q <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
				end
				ST_CYC: begin
					if (scan_take) begin
						cycle_q <= alu_sum;
					end
					k_q <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
				end
				ST_BASE: begin
					pend_q <= alu_sum;
					k_q    <= k_q + 1'b1;
					ovf_q  <= 1'b0;
					step_q <= '0;
				end
				ST_SEARCH: begin
					if (cand_past) begin
						if (search_stop) begin
							ovf_q <= 1'b1;
						end else begin
							pend_q <= alu_sum;
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					k_q <= '0;
				end
			endcase

			if (out_valid_q && results.ready && !(state_q == ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q  <= frames.now;
			fire_q <= fire_now;
		end
		if (state_q == ST_FINISH && out_load) begin
			o_fire_q    <= fire_q;
			o_running_q <= running_q;
			o_count_q   <= fire_cnt_q;
			o_lag_q     <= lag_q;
			o_cycle_q   <= cycle_q;
			o_pend_q    <= pend_q;
			o_ovf_q     <= ovf_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.fire            = o_fire_q;
	assign results.running         = o_running_q;
	assign results.trigger_count   = o_count_q;
	assign results.min_lag         = o_lag_q;
	assign results.cycle_time      = o_cycle_q;
	assign results.pending_trigger = o_pend_q;
	assign results.search_overflow = o_ovf_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_fire_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fire_now) |=> fire_cnt_q == $past(fire_cnt_q) + 1'b1)
		else $error("trigger counter did not advance on fire");

	a_plan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && start_plan) |=> (state_q == ST_LAG && k_q == '0))
		else $error("planning did not start with a fresh scan");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_MAX)
		else $error("candidate search ran past its limit");

	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_load) |=> (results.valid && state_q == ST_IDLE))
		else $error("finished item was not presented");

endmodule

`default_nettype wire

// ----- design/ctts_windows.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctts_windows
// Sync, arrival and global stamp windows: indexed fill while collecting,
// shift-in while running, rotation for the planning scan.
// ----------------------------------------------------------------------------
module ctts_windows import ctts_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  wire logic                        clk,
	input  wire win_ctl_t                    ctl,
	input  wire logic [$clog2(WINDOW)-1:0]   sync_idx,
	input  wire logic [$clog2(WINDOW)-1:0]   glob_idx,
	input  wire logic [TS_W-1:0]             now,
	input  wire logic [TS_W-1:0]             payload,
	output logic      [TS_W-1:0]             sync1,
	output logic      [TS_W-1:0]             arr0,
	output logic      [TS_W-1:0]             glob0,
	output logic      [TS_W-1:0]             glob1,
	output logic      [TS_W-1:0]             glob_last
);

	localparam int IW = $clog2(WINDOW);

	logic [TS_W-1:0] sync_q [WINDOW];
	logic [TS_W-1:0] arr_q  [WINDOW];
	logic [TS_W-1:0] glob_q [WINDOW];

	for (genvar k = 0; k < WINDOW; k++) begin : g_entry
		localparam int NXT = (k + 1) % WINDOW;
		localparam logic [IW-1:0] IDX = IW'(k);
		logic [TS_W-1:0] sync_in;
		logic [TS_W-1:0] arr_in;
		logic [TS_W-1:0] glob_in;

		if (k == WINDOW - 1) begin : g_tail
			assign sync_in = payload;
			assign arr_in  = now;
			assign glob_in = payload;
		end else begin : g_body
			assign sync_in = sync_q[k+1];
			assign arr_in  = arr_q[k+1];
			assign glob_in = glob_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.rot_sync) begin
				sync_q[k] <= sync_q[NXT];
				arr_q[k]  <= arr_q[NXT];
			end else if (ctl.shift_sync) begin
				sync_q[k] <= sync_in;
				arr_q[k]  <= arr_in;
			end else if (ctl.wr_sync && sync_idx == IDX) begin
				sync_q[k] <= payload;
				arr_q[k]  <= now;
			end

			if (ctl.rot_glob) begin
				glob_q[k] <= glob_q[NXT];
			end else if (ctl.shift_glob) begin
				glob_q[k] <= glob_in;
			end else if (ctl.wr_glob && glob_idx == IDX) begin
				glob_q[k] <= payload;
			end
		end
	end

	assign sync1     = sync_q[1];
	assign arr0      = arr_q[0];
	assign glob0     = glob_q[0];
	assign glob1     = glob_q[1];
	assign glob_last = glob_q[WINDOW-1];

endmodule

`default_nettype wire
